[hdl/br1_pkg.sv]
// shared types and constants of the byterun1 row decoder
package br1_pkg;

  localparam logic [1:0] PHASE_CONTROL = 2'd0;
  localparam logic [1:0] PHASE_LITERAL = 2'd1;
  localparam logic [1:0] PHASE_RUN     = 2'd2;

  localparam logic [7:0] NOOP_CODE = 8'h80;

  localparam logic CFG_COMPRESSED = 1'b0;
  localparam logic CFG_ROW_BYTES  = 1'b1;

  localparam int DATA_W  = 8;
  localparam int BYTES_W = 64;
  localparam int COUNT_W = 4;
  localparam int ROWB_W  = 9;
  localparam int OUT_TDATA_W = ((BYTES_W + COUNT_W + 7) / 8) * 8;

  typedef struct packed {
    logic take;
    logic emit;
  } br1_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic run_next;
    logic group_last;
  } br1_status_t;

endpackage

[hdl/br1_ctrl.sv]
// controller state machine: item intake and run group emission
module br1_ctrl import br1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  br1_status_t status,
  output br1_cmd_t    cmd
);

  localparam logic S_ACCEPT = 1'b0;
  localparam logic S_RUN    = 1'b1;

  logic state;
  logic state_next;

  assign in_ready = (state == S_ACCEPT) && status.slot_free;
  assign cmd.take = in_valid && in_ready;
  assign cmd.emit = (state == S_RUN) && status.slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_ACCEPT: if (cmd.take && status.run_next) state_next = S_RUN;
      S_RUN:    if (cmd.emit && status.group_last) state_next = S_ACCEPT;
      default:  state_next = S_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_ACCEPT;
    else state <= state_next;
  end

endmodule

[hdl/br1_datapath.sv]
// datapath: config registers, decode counters, row position and output register
module br1_datapath import br1_pkg::*; #(
  parameter int MAX_ROW_BYTES    = 256,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [ROWB_W-1:0]  cfg_data,
  input  logic [DATA_W-1:0]  data_byte,
  input  br1_cmd_t           cmd,
  output br1_status_t        status,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [BYTES_W-1:0] packed_bytes,
  output logic [COUNT_W-1:0] byte_count,
  output logic               row_end,
  output logic               last_of_run
);

  localparam int PW = $clog2(MAX_ROW_BYTES + 1);
  localparam int SW = ((PW > ROWB_W) ? PW : ROWB_W) + 1;
  localparam logic [SW-1:0] MAX_ROW = SW'(MAX_ROW_BYTES);
  localparam logic [7:0] BPR = 8'(BYTES_PER_RESULT);

  logic              compressed;
  logic [ROWB_W-1:0] row_bytes;
  logic [1:0]        phase;
  logic [7:0]        literal_left;
  logic [7:0]        run_length;
  logic [PW-1:0]     row_position;
  logic [7:0]        run_byte;
  logic [7:0]        run_len;
  logic [7:0]        run_rem;

  logic [SW-1:0] rowlen, pos_n, left, sum1, sum_run, lit_req, run_req, run_clamp;
  logic [7:0]    grp;
  logic          byte_out;
  logic          is_lit;
  logic          is_run;
  logic [BYTES_W-1:0] grp_bytes;

  assign is_lit = compressed && (phase == PHASE_LITERAL);
  assign is_run = compressed && (phase == PHASE_RUN);
  assign byte_out = !compressed || is_lit;

  always_comb begin
    if (row_bytes == '0) rowlen = SW'(1);
    else if (SW'(row_bytes) > MAX_ROW) rowlen = MAX_ROW;
    else rowlen = SW'(row_bytes);
    pos_n   = (SW'(row_position) >= rowlen) ? '0 : SW'(row_position);
    left    = rowlen - pos_n;
    sum1    = pos_n + SW'(1);
    sum_run = SW'(row_position) + SW'(run_len);
    lit_req = SW'(data_byte) + SW'(1);
    run_req = SW'(257) - SW'(data_byte);
    run_clamp = (SW'(run_length) > left) ? left : SW'(run_length);
    if (run_clamp == '0) run_clamp = SW'(1);
    grp = (run_rem > BPR) ? BPR : run_rem;
    for (int i = 0; i < 8; i++) begin
      grp_bytes[8*i +: 8] = (i < BYTES_PER_RESULT && 8'(i) < grp) ? run_byte : 8'h00;
    end
  end

  assign status.slot_free  = !out_valid || out_ready;
  assign status.run_next   = is_run;
  assign status.group_last = (run_rem <= BPR);

  // config and decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      compressed   <= 1'b1;
      row_bytes    <= ROWB_W'(40);
      phase        <= PHASE_CONTROL;
      literal_left <= '0;
      run_length   <= '0;
      row_position <= '0;
      run_rem      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COMPRESSED: compressed <= cfg_data[0];
          CFG_ROW_BYTES:  row_bytes  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take) begin
        if (byte_out) begin
          row_position <= (sum1 >= rowlen) ? '0 : sum1[PW-1:0];
          if (is_lit) begin
            if (literal_left <= 8'd1) begin
              literal_left <= '0;
              phase        <= PHASE_CONTROL;
            end else begin
              literal_left <= literal_left - 8'd1;
            end
          end
        end else begin
          row_position <= pos_n[PW-1:0];
          if (is_run) begin
            run_rem    <= run_clamp[7:0];
            run_length <= '0;
            phase      <= PHASE_CONTROL;
          end else if (data_byte < NOOP_CODE) begin
            literal_left <= (lit_req > left) ? left[7:0] : lit_req[7:0];
            phase        <= PHASE_LITERAL;
          end else if (data_byte != NOOP_CODE) begin
            run_length <= (run_req > left) ? left[7:0] : run_req[7:0];
            phase      <= PHASE_RUN;
          end else begin
            phase <= PHASE_CONTROL;
          end
        end
      end
      if (cmd.emit) begin
        run_rem <= run_rem - grp;
        if (status.group_last) row_position <= (sum_run >= rowlen) ? '0 : sum_run[PW-1:0];
      end
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (cmd.take && is_run) begin
      run_byte <= data_byte;
      run_len  <= run_clamp[7:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if ((cmd.take && byte_out) || cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.take && byte_out) begin
      packed_bytes <= BYTES_W'(data_byte);
      byte_count   <= COUNT_W'(1);
      row_end      <= (sum1 >= rowlen);
      last_of_run  <= 1'b1;
    end else if (cmd.emit) begin
      packed_bytes <= grp_bytes;
      byte_count   <= grp[COUNT_W-1:0];
      row_end      <= status.group_last && (sum_run >= rowlen);
      last_of_run  <= status.group_last;
    end
  end

endmodule

[hdl/byterun1_row_decoder.sv]
// byterun1 row decoder: one input byte per transfer, run groups stall the input
// output: a literal or pass-through byte is loaded into the output register when it
// transfers; a run byte moves the controller to S_RUN, which then emits its groups
// throughput: one byte per cycle for literals and pass-through while the output
// register is free; control and no-op bytes produce no output; a run byte holds the
// input while the group emitter drains through the single output register
// reset: synchronous, restores compressed = 1, row_bytes = 40 and an empty pipeline
module byterun1_row_decoder import br1_pkg::*; #(
  parameter int MAX_ROW_BYTES    = 256,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [ROWB_W-1:0]      cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // data_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // packed_bytes, byte_count, zero pad
  output logic                   m_axis_tlast,   // last_of_run
  output logic                   m_axis_tuser    // row_end
);

  br1_cmd_t           cmd;
  br1_status_t        status;
  logic [BYTES_W-1:0] packed_bytes;
  logic [COUNT_W-1:0] byte_count;

  br1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  br1_datapath #(
    .MAX_ROW_BYTES    (MAX_ROW_BYTES),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (s_axis_tdata),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .packed_bytes (packed_bytes),
    .byte_count   (byte_count),
    .row_end      (m_axis_tuser),
    .last_of_run  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - BYTES_W - COUNT_W){1'b0}}, byte_count, packed_bytes};

endmodule
